### sv/lebs_pkg.sv
`default_nettype none

package lebs_pkg;

    localparam int unsigned DUR_W      = 16;
    localparam int unsigned REP_W      = 4;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // operation codes (s_tuser)
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_ON     = 3'd1;
    localparam logic [OP_W-1:0] OP_OFF    = 3'd2;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd3;
    localparam logic [OP_W-1:0] OP_START  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEATS  = 2'd3;

    localparam logic [DUR_W-1:0] ON_TIME_RST  = 16'd200;
    localparam logic [DUR_W-1:0] OFF_TIME_RST = 16'd250;
    localparam logic [DUR_W-1:0] GAP_TIME_RST = 16'd1300;
    localparam logic [REP_W-1:0] REPEATS_RST  = 4'd4;

    typedef struct packed {
        logic [DUR_W-1:0] on_ms;
        logic [DUR_W-1:0] off_ms;
        logic [DUR_W-1:0] gap_ms;
        logic [REP_W-1:0] repeats;
    } cfg_t;

    typedef struct packed {
        logic              step;
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
    } seq_req_t;

    typedef struct packed {
        logic led;
        logic busy;
    } seq_stat_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LIT  = 4'b0010,
        PH_DARK = 4'b0100,
        PH_GAP  = 4'b1000
    } phase_t;

    function automatic logic [DUR_W-1:0] dur_min1(input logic [DUR_W-1:0] v);
        return (v == '0) ? DUR_W'(1) : v;
    endfunction

    function automatic logic [REP_W-1:0] rep_min1(input logic [REP_W-1:0] v);
        return (v == '0) ? REP_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

### sv/lebs_cfg.sv
`default_nettype none

module lebs_cfg
    import lebs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_ms   <= ON_TIME_RST;
            cfg_reg.off_ms  <= OFF_TIME_RST;
            cfg_reg.gap_ms  <= GAP_TIME_RST;
            cfg_reg.repeats <= REPEATS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ON_TIME:  cfg_reg.on_ms   <= wr_data[DUR_W-1:0];
                CFG_OFF_TIME: cfg_reg.off_ms  <= wr_data[DUR_W-1:0];
                CFG_GAP_TIME: cfg_reg.gap_ms  <= wr_data[DUR_W-1:0];
                CFG_REPEATS:  cfg_reg.repeats <= wr_data[REP_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### sv/lebs_seq.sv
`default_nettype none

module lebs_seq
    import lebs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire seq_req_t req,
    output seq_stat_t     stat
);

    logic              led_reg,          led_next;
    phase_t            phase_reg,        phase_next;
    logic [DUR_W-1:0]  ticks_left_reg,   ticks_left_next;
    logic [CODE_W-1:0] blinks_done_reg,  blinks_done_next;
    logic [CODE_W-1:0] blinks_total_reg, blinks_total_next;
    logic [REP_W-1:0]  groups_done_reg,  groups_done_next;

    logic [CODE_W-1:0] blinks_inc;
    logic [REP_W-1:0]  groups_inc;

    assign blinks_inc = blinks_done_reg + CODE_W'(1);
    assign groups_inc = groups_done_reg + REP_W'(1);

    always_comb
    begin
        led_next          = led_reg;
        phase_next        = phase_reg;
        ticks_left_next   = ticks_left_reg;
        blinks_done_next  = blinks_done_reg;
        blinks_total_next = blinks_total_reg;
        groups_done_next  = groups_done_reg;

        if (req.step)
        begin
            if (req.op inside {OP_ON, OP_OFF, OP_TOGGLE, OP_START})
            begin
                phase_next        = PH_IDLE;
                ticks_left_next   = '0;
                blinks_done_next  = '0;
                blinks_total_next = '0;
                groups_done_next  = '0;
            end

            case (req.op)
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (ticks_left_reg > DUR_W'(1))
                        begin
                            ticks_left_next = ticks_left_reg - DUR_W'(1);
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_LIT:
                                begin
                                    phase_next      = PH_DARK;
                                    led_next        = 1'b0;
                                    ticks_left_next = dur_min1(cfg.off_ms);
                                end
                                PH_DARK:
                                begin
                                    blinks_done_next = blinks_inc;
                                    if (blinks_inc < blinks_total_reg)
                                    begin
                                        phase_next      = PH_LIT;
                                        led_next        = 1'b1;
                                        ticks_left_next = dur_min1(cfg.on_ms);
                                    end
                                    else
                                    begin
                                        phase_next      = PH_GAP;
                                        led_next        = 1'b0;
                                        ticks_left_next = dur_min1(cfg.gap_ms);
                                    end
                                end
                                PH_GAP:
                                begin
                                    groups_done_next = groups_inc;
                                    if (groups_inc < rep_min1(cfg.repeats))
                                    begin
                                        blinks_done_next = '0;
                                        phase_next       = PH_LIT;
                                        led_next         = 1'b1;
                                        ticks_left_next  = dur_min1(cfg.on_ms);
                                    end
                                    else
                                    begin
                                        phase_next        = PH_IDLE;
                                        led_next          = 1'b0;
                                        ticks_left_next   = '0;
                                        blinks_done_next  = '0;
                                        blinks_total_next = '0;
                                        groups_done_next  = '0;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                OP_ON:     led_next = 1'b1;
                OP_OFF:    led_next = 1'b0;
                OP_TOGGLE: led_next = ~led_reg;
                OP_START:
                begin
                    blinks_total_next = (req.code == '0) ? CODE_W'(1) : req.code;
                    phase_next        = PH_LIT;
                    led_next          = 1'b1;
                    ticks_left_next   = dur_min1(cfg.on_ms);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg          <= 1'b0;
            phase_reg        <= PH_IDLE;
            ticks_left_reg   <= '0;
            blinks_done_reg  <= '0;
            blinks_total_reg <= '0;
            groups_done_reg  <= '0;
        end
        else
        begin
            led_reg          <= led_next;
            phase_reg        <= phase_next;
            ticks_left_reg   <= ticks_left_next;
            blinks_done_reg  <= blinks_done_next;
            blinks_total_reg <= blinks_total_next;
            groups_done_reg  <= groups_done_next;
        end
    end

    // state registers double as the result register
    assign stat.led  = led_reg;
    assign stat.busy = (phase_reg != PH_IDLE);

endmodule

`default_nettype wire

### sv/led_error_blink_sequencer_unit.sv
`default_nettype none

// Status LED sequencer with error blink codes. Each input beat is a 1 ms tick or a
// command (on, off, toggle, start error code) and yields exactly one output beat
// with the LED level and a pattern-busy flag after that beat. An error code blinks
// the LED code times (code 0 gives one blink), on_time lit and off_time dark per
// blink, then gap_time dark, and the group repeats group_repeats times before the
// LED ends off; on, off and toggle cancel a running pattern. Each input beat passes
// through one input register, then one state update that also forms the result
// register. Throughput is one beat per clock while the output side keeps taking
// beats. The configuration port is always ready and should be written only while
// no beat is in flight.
module led_error_blink_sequencer_unit
    import lebs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] error_code
    input  wire logic [OP_W-1:0]       s_tuser,   // [2:0] operation
    output wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    output wire logic [7:0]            m_tdata,   // [0] led_level, [7:1] zero
    output wire logic                  m_tuser,   // [0] pattern_busy
    input  wire logic                  cfg_valid,
    output wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    seq_req_t  req;
    seq_stat_t stat;

    logic              in_valid_reg, in_valid_next;
    logic [OP_W-1:0]   in_op_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic              m_valid_reg,  m_valid_next;
    logic              advance;
    logic              s_beat;

    assign cfg_ready = 1'b1;

    lebs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_op_reg   <= s_tuser;
            in_code_reg <= s_tdata[CODE_W-1:0];
        end
    end

    assign req.step = advance;
    assign req.op   = in_op_reg;
    assign req.code = in_code_reg;

    lebs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .stat  (stat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, stat.led};
    assign m_tuser  = stat.busy;

endmodule

`default_nettype wire

### sv/lebs_checker.sv
`default_nettype none

module lebs_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // empty output side never blocks input
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // output is valid after every accepted beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result missing after accepted beat");

    // unused result bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("padding bits set in result");

endmodule

bind led_error_blink_sequencer_unit lebs_checker u_lebs_checker (.*);

`default_nettype wire
